// ----- sv/mwpc_pkg.sv -----
package mwpc_pkg;

	localparam int WIN_DEPTH = 10;
	localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int SMP_W     = 8;
	localparam int CNT_W     = 8;
	localparam int PWM_W     = 15;
	localparam int CFG_IDX_W = 3;

	localparam logic [PWM_W-1:0] PWM_FULL = 15'h7FFF;

	// run status codes
	localparam logic [1:0] RS_OFF = 2'd0;
	localparam logic [1:0] RS_RUN = 2'd1;
	localparam logic [1:0] RS_END = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_CEILING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_CYCLES     = 3'd4;

	typedef struct packed {
		logic [SMP_W-1:0] dry_threshold;
		logic [SMP_W-1:0] sample_ceiling;
		logic [CNT_W-1:0] on_ticks;
		logic [CNT_W-1:0] off_ticks;
		logic [CNT_W-1:0] run_cycles;
	} cfg_t;

	typedef struct packed {
		logic [1:0] run_state;
		logic       drive_hold;
		logic       period_flag;
	} run_stat_t;

endpackage

// ----- sv/mwpc_ring.sv -----
module mwpc_ring
	import mwpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [SMP_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic             rd_valid,
	output logic [SMP_W-1:0] rd_data
);

	logic [SMP_W-1:0]     mem [WIN_DEPTH];
	logic [WIN_DEPTH-1:0] ent_vld_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic [SMP_W-1:0]     rd_raw_s1;
	logic                 rd_ent_vld_s1;
	logic                 rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q     <= '0;
			wr_idx_q      <= '0;
			rd_ent_vld_s1 <= 1'b0;
			rd_valid_s1   <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				rd_ent_vld_s1 <= ent_vld_q[rd_addr];
			end
			if (wr_en) begin
				ent_vld_q[wr_idx_q] <= 1'b1;
				// advance and wrap at the window depth
				if (wr_idx_q == IDX_W'(WIN_DEPTH - 1)) begin
					wr_idx_q <= '0;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
		end
	end

	// an entry never written reads as the cleared value
	assign rd_valid = rd_valid_s1;
	assign rd_data  = rd_ent_vld_s1 ? rd_raw_s1 : '0;

endmodule

// ----- sv/mwpc_run.sv -----
module mwpc_run
	import mwpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  logic      request,
	input  cfg_t      cfg,
	output run_stat_t nxt
);

	logic [1:0]       run_state_q;
	logic             in_on_q;
	logic [CNT_W-1:0] on_cnt_q;
	logic [CNT_W-1:0] off_cnt_q;
	logic [CNT_W-1:0] cyc_q;
	logic             period_q;
	logic             drive_q;

	logic [1:0]       run_state_d;
	logic             in_on_d;
	logic [CNT_W-1:0] on_cnt_d;
	logic [CNT_W-1:0] off_cnt_d;
	logic [CNT_W-1:0] cyc_d;
	logic             drive_d;

	always_comb begin
		run_state_d = run_state_q;
		in_on_d     = in_on_q;
		on_cnt_d    = on_cnt_q;
		off_cnt_d   = off_cnt_q;
		cyc_d       = cyc_q;
		drive_d     = drive_q;
		priority if (!request && run_state_q != RS_RUN) begin
			run_state_d = RS_OFF;
			drive_d     = 1'b0;
		end else if (request && run_state_q == RS_OFF) begin
			// start a run; hold the drive this tick
			run_state_d = RS_RUN;
			on_cnt_d    = '0;
			off_cnt_d   = '0;
			cyc_d       = '0;
			in_on_d     = 1'b1;
		end else begin
			if (run_state_q == RS_END) begin
				drive_d = 1'b0;
			end else begin
				drive_d = in_on_q;
				if (in_on_q) begin
					if (on_cnt_q > cfg.on_ticks) begin
						on_cnt_d = '0;
						in_on_d  = 1'b0;
					end else begin
						on_cnt_d = on_cnt_q + 1'b1;
					end
				end else begin
					if (off_cnt_q > cfg.off_ticks) begin
						off_cnt_d = '0;
						in_on_d   = 1'b1;
						cyc_d     = cyc_q + 1'b1;
					end else begin
						off_cnt_d = off_cnt_q + 1'b1;
					end
				end
			end
			if (cyc_d > cfg.run_cycles) begin
				run_state_d = RS_END;
			end
		end
	end

	assign nxt.run_state   = run_state_d;
	assign nxt.drive_hold  = drive_d;
	assign nxt.period_flag = period_q | request;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_state_q <= RS_OFF;
			in_on_q     <= 1'b0;
			on_cnt_q    <= '0;
			off_cnt_q   <= '0;
			cyc_q       <= '0;
			period_q    <= 1'b0;
			drive_q     <= 1'b0;
		end else if (go) begin
			run_state_q <= run_state_d;
			in_on_q     <= in_on_d;
			on_cnt_q    <= on_cnt_d;
			off_cnt_q   <= off_cnt_d;
			cyc_q       <= cyc_d;
			period_q    <= nxt.period_flag;
			drive_q     <= drive_d;
		end
	end

endmodule

// ----- sv/moisture_window_pump_cycler_core.sv -----
// Pump cycler driven by 100 ms moisture ticks.
// Input channel (in_valid/in_ready): one word per tick with moisture_sample,
// diag_state and diag_request. Output channel (out_valid/out_ready): one
// result word per tick with the held pump drive, pwm compare, run status,
// the dry verdict of the sample window, the sticky request flag and an
// echo of the sample.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0..4 selects dry threshold, ceiling, on ticks, off ticks and run
// cycles. Write only while no tick is in flight.
// Each tick runs from acceptance to result as follows: the accepting edge
// writes the sample into the window memory, the walk reads the whole window one
// entry per cycle through the single read port, the flush state drains the registered
// read, and the emit state updates the run state and loads the output register. The
// next tick is accepted no earlier than the cycle after, so ticks never overlap.
// A result waiting in the output register does not block the next tick's
// walk; only the final update waits for the receiver to take it.
// Reset clears the window (all entries read as zero), the run state and the
// control and config registers to their defaults; output data is not reset.
module moisture_window_pump_cycler_core
	import mwpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SMP_W-1:0]     moisture_sample,
	input  logic                 diag_state,
	input  logic                 diag_request,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 pump_drive,
	output logic [PWM_W-1:0]     pwm_compare,
	output logic [1:0]           run_status,
	output logic                 soil_dry,
	output logic                 period_seen,
	output logic [SMP_W-1:0]     latest_sample,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SMP_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [SMP_W-1:0] sample_q;
	logic             dstate_q;
	logic             dreq_q;
	logic             dry_q;
	cfg_t             cfg_q;

	logic             in_acc;
	logic             rd_en;
	logic             rd_valid;
	logic [SMP_W-1:0] rd_data;
	logic             ent_ok;
	logic             request;
	logic             emit;
	logic             out_free;
	run_stat_t        run_nxt;

	logic             out_valid_q;
	logic             drive_q;
	logic [1:0]       status_q;
	logic             dry_out_q;
	logic             period_out_q;
	logic [SMP_W-1:0] sample_out_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign rd_en     = (state_q == ST_WALK);
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_EMIT) && out_free;
	assign ent_ok    = !(rd_data < cfg_q.dry_threshold || rd_data > cfg_q.sample_ceiling);
	assign request   = dry_q || (dstate_q && dreq_q);

	mwpc_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc),
		.wr_data  (moisture_sample),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr_q),
		.rd_valid (rd_valid),
		.rd_data  (rd_data)
	);

	mwpc_run u_run (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (emit),
		.request (request),
		.cfg     (cfg_q),
		.nxt     (run_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_threshold  <= 8'd80;
			cfg_q.sample_ceiling <= 8'd100;
			cfg_q.on_ticks       <= 8'd40;
			cfg_q.off_ticks      <= 8'd80;
			cfg_q.run_cycles     <= 8'd15;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DRY_THRESHOLD:  cfg_q.dry_threshold  <= cfg_data;
				CFG_SAMPLE_CEILING: cfg_q.sample_ceiling <= cfg_data;
				CFG_ON_TICKS:       cfg_q.on_ticks       <= cfg_data;
				CFG_OFF_TICKS:      cfg_q.off_ticks      <= cfg_data;
				CFG_RUN_CYCLES:     cfg_q.run_cycles     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= moisture_sample;
			dstate_q <= diag_state;
			dreq_q   <= diag_request;
		end
		if (emit) begin
			drive_q      <= run_nxt.drive_hold;
			status_q     <= run_nxt.run_state;
			dry_out_q    <= dry_q;
			period_out_q <= run_nxt.period_flag;
			sample_out_q <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_addr_q   <= '0;
			dry_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_valid) begin
				dry_q <= dry_q && ent_ok;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_addr_q <= '0;
						dry_q     <= 1'b1;
						state_q   <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (rd_addr_q == IDX_W'(WIN_DEPTH - 1)) begin
						state_q <= ST_FLUSH;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					// last entry's compare lands this cycle
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pump_drive    = drive_q;
	assign pwm_compare   = drive_q ? PWM_FULL : '0;
	assign run_status    = status_q;
	assign soil_dry      = dry_out_q;
	assign period_seen   = period_out_q;
	assign latest_sample = sample_out_q;

endmodule

// ----- dv/moisture_window_pump_cycler_core_tb.sv -----
`timescale 1ns / 100ps

module moisture_window_pump_cycler_core_tb;
	import mwpc_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 30;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic [SMP_W-1:0] sample;
		logic             dstate;
		logic             dreq;
	} tick_word_t;

	typedef struct {
		logic             pump;
		logic [PWM_W-1:0] pwm;
		logic [1:0]       status;
		logic             dry;
		logic             seen;
		logic [SMP_W-1:0] sample;
	} pump_report_t;

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 in_valid        = 1'b0;
	logic                 in_ready;
	logic [SMP_W-1:0]     moisture_sample = '0;
	logic                 diag_state      = 1'b0;
	logic                 diag_request    = 1'b0;
	logic                 out_valid;
	logic                 out_ready       = 1'b0;
	logic                 pump_drive;
	logic [PWM_W-1:0]     pwm_compare;
	logic [1:0]           run_status;
	logic                 soil_dry;
	logic                 period_seen;
	logic [SMP_W-1:0]     latest_sample;
	logic                 cfg_valid       = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index       = '0;
	logic [SMP_W-1:0]     cfg_data        = '0;

	tick_word_t   ticks_to_send[$];
	pump_report_t pump_reports_due[$];
	logic         in_taken      = 1'b0;
	int           in_idle_pct   = 0;
	int           out_stall_pct = 0;
	int           fail_count    = 0;
	int           cycle_count   = 0;

	// shadow of the cycler: live registers and run state
	logic [SMP_W-1:0] dry_thr  = 8'd80;
	logic [SMP_W-1:0] ceil_lim = 8'd100;
	logic [CNT_W-1:0] on_lim   = 8'd40;
	logic [CNT_W-1:0] off_lim  = 8'd80;
	logic [CNT_W-1:0] cyc_lim  = 8'd15;
	logic [SMP_W-1:0] win [WIN_DEPTH] = '{default: '0};
	int               wr_ptr   = 0;
	logic [1:0]       run_st   = RS_OFF;
	logic             on_phase = 1'b0;
	logic [CNT_W-1:0] on_cnt   = '0;
	logic [CNT_W-1:0] off_cnt  = '0;
	logic [CNT_W-1:0] cyc_cnt  = '0;
	logic             seen_flag = 1'b0;
	logic             drive    = 1'b0;

	moisture_window_pump_cycler_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.moisture_sample (moisture_sample),
		.diag_state      (diag_state),
		.diag_request    (diag_request),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pump_drive      (pump_drive),
		.pwm_compare     (pwm_compare),
		.run_status      (run_status),
		.soil_dry        (soil_dry),
		.period_seen     (period_seen),
		.latest_sample   (latest_sample),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	// Update the shadow for one accepted tick and queue the report it causes.
	task automatic step_pump_cycler(input tick_word_t w);
		logic         dry;
		logic         req;
		pump_report_t r;
		win[wr_ptr] = w.sample;
		wr_ptr = (wr_ptr + 1 >= WIN_DEPTH) ? 0 : wr_ptr + 1;
		dry = 1'b1;
		foreach (win[i]) begin
			if (win[i] < dry_thr || win[i] > ceil_lim)
				dry = 1'b0;
		end
		req = dry || (w.dstate && w.dreq);
		if (!req && run_st != RS_RUN) begin
			run_st = RS_OFF;
			drive = 1'b0;
		end else if (req && run_st == RS_OFF) begin
			// start of a run: drive holds its old value this tick
			run_st = RS_RUN;
			on_cnt = '0;
			off_cnt = '0;
			cyc_cnt = '0;
			on_phase = 1'b1;
		end else begin
			if (run_st == RS_END) begin
				drive = 1'b0;
			end else begin
				drive = on_phase;
				if (on_phase) begin
					if (on_cnt > on_lim) begin
						on_cnt = '0;
						on_phase = 1'b0;
					end else begin
						on_cnt = on_cnt + 1'b1;
					end
				end else begin
					if (off_cnt > off_lim) begin
						off_cnt = '0;
						on_phase = 1'b1;
						cyc_cnt = cyc_cnt + 1'b1;
					end else begin
						off_cnt = off_cnt + 1'b1;
					end
				end
			end
			if (cyc_cnt > cyc_lim)
				run_st = RS_END;
		end
		if (req)
			seen_flag = 1'b1;
		r.pump   = drive;
		r.pwm    = drive ? PWM_FULL : '0;
		r.status = run_st;
		r.dry    = dry;
		r.seen   = seen_flag;
		r.sample = w.sample;
		pump_reports_due.push_back(r);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// driver: new word only after the previous one was taken
	always @(negedge clk) begin : drv
		tick_word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (ticks_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				w = ticks_to_send.pop_front();
				in_valid        <= 1'b1;
				moisture_sample <= w.sample;
				diag_state      <= w.dstate;
				diag_request    <= w.dreq;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= out_stall_pct);
	end

	// monitor: check reports, track register writes, predict accepted ticks
	always @(posedge clk) begin : mon
		pump_report_t e;
		tick_word_t   w;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DRY_THRESHOLD:  dry_thr  = cfg_data;
					CFG_SAMPLE_CEILING: ceil_lim = cfg_data;
					CFG_ON_TICKS:       on_lim   = cfg_data;
					CFG_OFF_TICKS:      off_lim  = cfg_data;
					CFG_RUN_CYCLES:     cyc_lim  = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pump_reports_due.size() == 0) begin
					$error("result word with none expected");
					fail_count++;
				end else begin
					e = pump_reports_due.pop_front();
					check_field("pump_drive", 32'(e.pump), 32'(pump_drive));
					check_field("pwm_compare", 32'(e.pwm), 32'(pwm_compare));
					check_field("run_status", 32'(e.status), 32'(run_status));
					check_field("soil_dry", 32'(e.dry), 32'(soil_dry));
					check_field("period_seen", 32'(e.seen), 32'(period_seen));
					check_field("latest_sample", 32'(e.sample), 32'(latest_sample));
				end
			end
			if (in_valid && in_ready) begin
				w.sample = moisture_sample;
				w.dstate = diag_state;
				w.dreq   = diag_request;
				step_pump_cycler(w);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_tick(input logic [SMP_W-1:0] s, input logic ds, input logic dr);
		tick_word_t w;
		w.sample = s;
		w.dstate = ds;
		w.dreq   = dr;
		ticks_to_send.push_back(w);
	endtask

	// Mostly dry stretches, often long enough to fill the window, broken by wet noise.
	task automatic queue_ticks(input int n);
		int  k;
		int  seg;
		bit  wet;
		logic [SMP_W-1:0] s;
		k = 0;
		while (k < n) begin
			wet = ($urandom_range(99) < 30);
			seg = wet ? $urandom_range(1, 6) : $urandom_range(8, 24);
			for (int j = 0; j < seg && k < n; j++) begin
				if (wet || dry_thr > ceil_lim || $urandom_range(99) < 3)
					s = 8'($urandom);
				else
					s = 8'($urandom_range(ceil_lim, dry_thr));
				push_tick(s, $urandom_range(99) < 30, 1'($urandom));
				k++;
			end
		end
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_cfg(input logic [7:0] thr, input logic [7:0] ceil_v,
			input logic [7:0] on_v, input logic [7:0] off_v, input logic [7:0] cyc_v);
		write_cfg(CFG_DRY_THRESHOLD, thr);
		write_cfg(CFG_SAMPLE_CEILING, ceil_v);
		write_cfg(CFG_ON_TICKS, on_v);
		write_cfg(CFG_OFF_TICKS, off_v);
		write_cfg(CFG_RUN_CYCLES, cyc_v);
	endtask

	task automatic wait_drained();
		while (ticks_to_send.size() != 0 || in_valid || pump_reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			1: begin in_idle_pct = 85; out_stall_pct = 0; end
			2: begin in_idle_pct = 0; out_stall_pct = 85; end
			3: begin in_idle_pct = 25; out_stall_pct = 25; end
			default: begin in_idle_pct = 0; out_stall_pct = 0; end
		endcase
	endtask

	initial begin : stim
		int thr_pick;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: diag combinations, run start, window filling dry
		set_idle(0);
		push_tick(8'd0, 1'b0, 1'b0);
		push_tick(8'd255, 1'b1, 1'b0);
		push_tick(8'd255, 1'b0, 1'b1);
		push_tick(8'd0, 1'b1, 1'b1);
		push_tick(8'd0, 1'b0, 1'b0);
		push_tick(8'd80, 1'b0, 1'b0);
		push_tick(8'd100, 1'b0, 1'b0);
		push_tick(8'd90, 1'b0, 1'b0);
		push_tick(8'd80, 1'b0, 1'b0);
		push_tick(8'd100, 1'b0, 1'b0);
		push_tick(8'd85, 1'b0, 1'b0);
		push_tick(8'd95, 1'b0, 1'b0);
		push_tick(8'd99, 1'b0, 1'b0);
		push_tick(8'd81, 1'b0, 1'b0);
		push_tick(8'd100, 1'b1, 1'b0);
		push_tick(8'd101, 1'b0, 1'b0);
		push_tick(8'd79, 1'b0, 1'b1);
		wait_drained();

		for (int p = 1; p <= 6; p++) begin
			thr_pick = $urandom_range(40, 120);
			case (p)
				1: write_all_cfg(8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
				5: write_all_cfg(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
				6: write_all_cfg(8'd255, 8'd0, 8'd254, 8'd254, 8'd254);
				default: write_all_cfg(8'(thr_pick), 8'(thr_pick + $urandom_range(0, 60)),
					8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
					8'($urandom_range(0, 3)));
			endcase
			if (p == 2)
				write_cfg(CFG_UNUSED, 8'($urandom));
			case (p)
				1: begin set_idle(0); queue_ticks(60); end
				2: begin set_idle(1); queue_ticks(180); end
				3: begin
					set_idle(2);
					queue_ticks(90);
					// hold the sender until every report is back
					wait_drained();
					queue_ticks(90);
				end
				4: begin set_idle(3); queue_ticks(160); end
				5: begin set_idle(0); queue_ticks(300); end
				default: begin set_idle(3); queue_ticks(60); end
			endcase
			// drop an ended run back to off before the next setting; a running run keeps running
			if (p >= 2 && p <= 4)
				push_tick('0, 1'b0, 1'b0);
			wait_drained();
		end

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
